### rtl/fir_pkg.sv
// Shared types and constants for the direct-form FIR filter.
package fir_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int COEFF_W     = 16;
   localparam int OUT_W       = 38;
   localparam int TAPCNT_W    = 7;
   localparam int CIDX_W      = 6;
   localparam int DIGIT_W     = 4;
   localparam int NUM_DIGITS  = COEFF_W / DIGIT_W;
   localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS);
   localparam int PROD_W      = SAMPLE_W + COEFF_W;
   localparam int PP_W        = SAMPLE_W + DIGIT_W + 1;
   localparam int HI_W        = PP_W - DIGIT_W;

   localparam logic [TAPCNT_W-1:0] TAP_COUNT_RESET = 7'd64;

   localparam logic MODE_FILTER = 1'b0;
   localparam logic MODE_COEFF  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_MUL,
      ST_ACC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic step;
      logic last;
      logic accum;
   } mac_ctrl_type;

   typedef struct packed {
      logic dl_we;
      logic coef_we;
   } store_ctrl_type;

endpackage

### rtl/fir_tap_store.sv
// Delay-line and coefficient memories with registered reads.
module fir_tap_store import fir_pkg::*; #(
   parameter int MAX_TAPS = 64,
   localparam int AW = $clog2(MAX_TAPS)
) (
   input  logic                       clock,
   input  store_ctrl_type             store_ctrl,
   input  logic [AW-1:0]              dl_waddr,
   input  logic signed [SAMPLE_W-1:0] dl_wdata,
   input  logic [AW-1:0]              dl_raddr,
   output logic signed [SAMPLE_W-1:0] dl_rdata,
   input  logic [AW-1:0]              coef_waddr,
   input  logic signed [COEFF_W-1:0]  coef_wdata,
   input  logic [AW-1:0]              coef_raddr,
   output logic signed [COEFF_W-1:0]  coef_rdata
);

   logic signed [SAMPLE_W-1:0] dl_mem   [MAX_TAPS];
   logic signed [COEFF_W-1:0]  coef_mem [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] dl_rdata_ff;
   logic signed [COEFF_W-1:0]  coef_rdata_ff;

   always_ff @(posedge clock) begin
      if (store_ctrl.dl_we) begin
         dl_mem[dl_waddr] <= dl_wdata;
      end
      dl_rdata_ff <= dl_mem[dl_raddr];
   end

   always_ff @(posedge clock) begin
      if (store_ctrl.coef_we) begin
         coef_mem[coef_waddr] <= coef_wdata;
      end
      coef_rdata_ff <= coef_mem[coef_raddr];
   end

   assign dl_rdata   = dl_rdata_ff;
   assign coef_rdata = coef_rdata_ff;

endmodule

### rtl/fir_digit_mac.sv
// Radix-16 digit-serial multiplier feeding the tap accumulator.
module fir_digit_mac import fir_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  mac_ctrl_type               mac_ctrl,
   input  logic signed [SAMPLE_W-1:0] mult_in,
   input  logic signed [COEFF_W-1:0]  coef_in,
   output logic signed [OUT_W-1:0]    acc
);

   logic signed [SAMPLE_W-1:0] mcand_ff;
   logic [COEFF_W-1:0]         coef_sr_ff, coef_sr_in;
   logic signed [HI_W-1:0]     hi_ff, hi_in;
   logic [SAMPLE_W-1:0]        lo_ff, lo_in;
   logic signed [OUT_W-1:0]    acc_ff, acc_in;

   logic [DIGIT_W-1:0]       digit;
   logic signed [DIGIT_W:0]  digit_s;
   logic signed [PP_W-1:0]   pp;
   logic signed [PP_W-1:0]   sum;
   logic [PROD_W-1:0]        prod;

   // lower digits are unsigned, the top digit carries the sign weight
   always_comb begin
      digit   = coef_sr_ff[DIGIT_W-1:0];
      digit_s = mac_ctrl.last ? {digit[DIGIT_W-1], digit} : {1'b0, digit};
      pp      = mcand_ff * digit_s;
      sum     = {{(PP_W-HI_W){hi_ff[HI_W-1]}}, hi_ff} + pp;
      prod    = {hi_ff[SAMPLE_W-1:0], lo_ff};
   end

   always_comb begin
      coef_sr_in = coef_sr_ff;
      hi_in      = hi_ff;
      lo_in      = lo_ff;
      if (mac_ctrl.load) begin
         coef_sr_in = coef_in;
         hi_in      = '0;
         lo_in      = '0;
      end else if (mac_ctrl.step) begin
         coef_sr_in = coef_sr_ff >> DIGIT_W;
         hi_in      = sum[PP_W-1:DIGIT_W];
         lo_in      = {sum[DIGIT_W-1:0], lo_ff[SAMPLE_W-1:DIGIT_W]};
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (mac_ctrl.clear) begin
         acc_in = '0;
      end else if (mac_ctrl.accum) begin
         acc_in = acc_ff + {{(OUT_W-PROD_W){prod[PROD_W-1]}}, prod};
      end
   end

   always_ff @(posedge clock) begin
      if (mac_ctrl.load) begin
         mcand_ff <= mult_in;
      end
      coef_sr_ff <= coef_sr_in;
      hi_ff      <= hi_in;
      lo_ff      <= lo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

### rtl/fir_ctrl.sv
// Sequencer: clearing pass, coefficient writes and the per-tap shift/MAC walk.
module fir_ctrl import fir_pkg::*; #(
   parameter int MAX_TAPS = 64,
   localparam int AW = $clog2(MAX_TAPS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [TAPCNT_W-1:0]        tap_count,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_mode,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic [CIDX_W-1:0]          req_coeff_index,
   input  logic signed [COEFF_W-1:0]  req_coeff_value,
   input  logic                       out_free,
   output logic                       result_load,
   output mac_ctrl_type               mac_ctrl,
   output logic signed [SAMPLE_W-1:0] mult_in,
   output store_ctrl_type             store_ctrl,
   output logic [AW-1:0]              dl_waddr,
   output logic signed [SAMPLE_W-1:0] dl_wdata,
   output logic [AW-1:0]              dl_raddr,
   input  logic signed [SAMPLE_W-1:0] dl_rdata,
   output logic [AW-1:0]              coef_waddr,
   output logic signed [COEFF_W-1:0]  coef_wdata,
   output logic [AW-1:0]              coef_raddr
);

   localparam int CW = $clog2(MAX_TAPS + 1);
   localparam int TW = (CW > TAPCNT_W) ? CW : TAPCNT_W;
   localparam int XW = (AW > CIDX_W) ? AW : CIDX_W;
   localparam logic [AW-1:0] LAST_IDX = AW'(MAX_TAPS - 1);
   localparam logic [TW-1:0] MAX_TAPS_C = TW'(MAX_TAPS);
   localparam logic [DIGIT_CNT_W-1:0] LAST_DIGIT = DIGIT_CNT_W'(NUM_DIGITS - 1);

   state_type state_ff, state_in;
   logic [AW-1:0]              idx_ff, clr_idx_ff;
   logic [DIGIT_CNT_W-1:0]     dig_cnt_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;

   logic                accept;
   logic                coef_in_range;
   logic [TW-1:0]       tc_ext, tc_m1;
   logic [XW-1:0]       cidx_ext;
   logic [AW-1:0]       start_idx;
   logic                last_digit;
   logic signed [SAMPLE_W-1:0] new_val;

   // active taps clamped to 1..MAX_TAPS, walk starts at the oldest one
   always_comb begin
      tc_ext = TW'(tap_count);
      tc_m1  = tc_ext - TW'(1);
      if (tap_count == '0) begin
         start_idx = '0;
      end else if (tc_ext > MAX_TAPS_C) begin
         start_idx = LAST_IDX;
      end else begin
         start_idx = tc_m1[AW-1:0];
      end
      cidx_ext      = XW'(req_coeff_index);
      coef_in_range = 32'(req_coeff_index) < 32'(MAX_TAPS);
   end

   assign accept     = req_valid && !req_stall;
   assign last_digit = dig_cnt_ff == LAST_DIGIT;
   assign new_val    = (idx_ff == '0) ? sample_ff : dl_rdata;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_idx_ff == LAST_IDX) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && req_mode == MODE_FILTER) state_in = ST_FETCH;
         end
         ST_FETCH: state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_MUL;
         ST_MUL: begin
            if (last_digit) state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = (idx_ff == '0) ? ST_DONE : ST_FETCH;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      result_load = 1'b0;
      mac_ctrl    = '0;
      store_ctrl  = '0;
      dl_waddr    = idx_ff;
      dl_wdata    = new_val;
      dl_raddr    = idx_ff - AW'(1);
      coef_waddr  = cidx_ext[AW-1:0];
      coef_wdata  = req_coeff_value;
      coef_raddr  = idx_ff;
      mult_in     = new_val;
      mac_ctrl.last = last_digit;
      unique case (state_ff)
         ST_CLEAR: begin
            store_ctrl.dl_we   = 1'b1;
            store_ctrl.coef_we = 1'b1;
            dl_waddr           = clr_idx_ff;
            dl_wdata           = '0;
            coef_waddr         = clr_idx_ff;
            coef_wdata         = '0;
         end
         ST_IDLE: begin
            req_stall          = 1'b0;
            mac_ctrl.clear     = accept && req_mode == MODE_FILTER;
            store_ctrl.coef_we = accept && req_mode == MODE_COEFF && coef_in_range;
         end
         ST_FETCH: begin
         end
         ST_LOAD: begin
            mac_ctrl.load    = 1'b1;
            store_ctrl.dl_we = 1'b1;
         end
         ST_MUL: begin
            mac_ctrl.step = 1'b1;
         end
         ST_ACC: begin
            mac_ctrl.accum = 1'b1;
         end
         ST_DONE: begin
            result_load = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_idx_ff <= '0;
         idx_ff     <= '0;
         dig_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_idx_ff <= clr_idx_ff + AW'(1);
         end
         if (state_ff == ST_IDLE && accept && req_mode == MODE_FILTER) begin
            idx_ff <= start_idx;
         end else if (state_ff == ST_ACC && idx_ff != '0) begin
            idx_ff <= idx_ff - AW'(1);
         end
         if (state_ff == ST_LOAD) begin
            dig_cnt_ff <= '0;
         end else if (state_ff == ST_MUL) begin
            dig_cnt_ff <= dig_cnt_ff + DIGIT_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_mode == MODE_FILTER) begin
         sample_ff <= req_sample;
      end
   end

endmodule

### rtl/fir_filter_direct_form.sv
// Direct-form FIR filter top level: tap-count register, output register, datapath.
//
// Request channel (req_*): valid/stall. req_mode selects a sample (filter) or a
// coefficient write. A coefficient write gives no response; an index at or
// beyond MAX_TAPS is dropped.
// Response channel (rsp_*): valid/stall, one rsp_filtered per sample request,
// the exact sum of delay-line entries times coefficients over the active taps.
// csr_wr_en/csr_wr_data load tap_count (reset 64); zero acts as 1, values above
// MAX_TAPS act as MAX_TAPS. Write it only while the filter is idle.
// Sequence: for each of the N active taps the sequencer steps through memory
// fetch, load, four radix-16 multiplier digits and accumulate; requests stay
// stalled meanwhile, and the next request is taken right after the response is
// handed to the output register.
// Reset: a clearing pass zeroes every entry of both memories, with req_stall
// held high; tap_count is reset at once and may be written meanwhile.
// Receiver stall: the response waits in the output register; further requests
// are still taken, and a finished sample waits until that register frees up.
module fir_filter_direct_form import fir_pkg::*; #(
   parameter int MAX_TAPS = 64,
   localparam int AW = $clog2(MAX_TAPS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [TAPCNT_W-1:0]        csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_mode,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic [CIDX_W-1:0]          req_coeff_index,
   input  logic signed [COEFF_W-1:0]  req_coeff_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [OUT_W-1:0]    rsp_filtered
);

   logic [TAPCNT_W-1:0]        tap_count_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]    rsp_filtered_ff;

   logic                       out_free;
   logic                       result_load;
   mac_ctrl_type               mac_ctrl;
   store_ctrl_type             store_ctrl;
   logic signed [SAMPLE_W-1:0] mult_in;
   logic [AW-1:0]              dl_waddr, dl_raddr, coef_waddr, coef_raddr;
   logic signed [SAMPLE_W-1:0] dl_wdata, dl_rdata;
   logic signed [COEFF_W-1:0]  coef_wdata, coef_rdata;
   logic signed [OUT_W-1:0]    acc;

   // tap count register
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_COUNT_RESET;
      end else if (csr_wr_en) begin
         tap_count_ff <= csr_wr_data;
      end
   end

   // output register: free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         rsp_filtered_ff <= acc;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

   fir_ctrl #(
      .MAX_TAPS(MAX_TAPS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .tap_count       (tap_count_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_sample      (req_sample),
      .req_coeff_index (req_coeff_index),
      .req_coeff_value (req_coeff_value),
      .out_free        (out_free),
      .result_load     (result_load),
      .mac_ctrl        (mac_ctrl),
      .mult_in         (mult_in),
      .store_ctrl      (store_ctrl),
      .dl_waddr        (dl_waddr),
      .dl_wdata        (dl_wdata),
      .dl_raddr        (dl_raddr),
      .dl_rdata        (dl_rdata),
      .coef_waddr      (coef_waddr),
      .coef_wdata      (coef_wdata),
      .coef_raddr      (coef_raddr)
   );

   fir_tap_store #(
      .MAX_TAPS(MAX_TAPS)
   ) u_store (
      .clock      (clock),
      .store_ctrl (store_ctrl),
      .dl_waddr   (dl_waddr),
      .dl_wdata   (dl_wdata),
      .dl_raddr   (dl_raddr),
      .dl_rdata   (dl_rdata),
      .coef_waddr (coef_waddr),
      .coef_wdata (coef_wdata),
      .coef_raddr (coef_raddr),
      .coef_rdata (coef_rdata)
   );

   fir_digit_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .mac_ctrl (mac_ctrl),
      .mult_in  (mult_in),
      .coef_in  (coef_rdata),
      .acc      (acc)
   );

endmodule
